@@ hw/rtl/wbps_pkg.sv @@
package wbps_pkg;

    localparam int SIG_BYTES        = 16;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 5;
    localparam int SIG_IDX_W        = 4;
    localparam int OUT_ADDR_W       = 32;
    localparam int DEF_MAX_PATTERN  = 16;
    localparam int DEF_ADDRESS_BITS = 32;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_LSB    = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [APB_ADDR_W-REG_LSB-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_BASE         = 3'd4
    } reg_idx_t;

    // effective settings seen by the cell row
    typedef struct packed {
        logic [SIG_BYTES-1:0][BYTE_W-1:0] sig;
        logic [SIG_BYTES-1:0]             wild;
        logic [LEN_W-1:0]                 len;
        logic [OUT_ADDR_W-1:0]            base;
    } cfg_t;

endpackage

@@ hw/rtl/wbps_if.sv @@
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

@@ hw/rtl/wbps_cfg.sv @@
module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    localparam int LIMIT_LEN = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

    logic [63:0]            pat_low_reg;
    logic [63:0]            pat_high_reg;
    logic [SIG_BYTES-1:0]   wild_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [OUT_ADDR_W-1:0]  base_reg;
    logic                   wr;
    reg_idx_t               idx;
    logic [LEN_W-1:0]       len_eff;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:REG_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= LEN_RESET;
            base_reg     <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_WILDCARD:     wild_reg     <= pwdata[SIG_BYTES-1:0];
                REG_LENGTH:       len_reg      <= pwdata[LEN_W-1:0];
                REG_BASE:         base_reg     <= pwdata[OUT_ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_WILDCARD:     prdata = APB_DATA_W'(wild_reg);
            REG_LENGTH:       prdata = APB_DATA_W'(len_reg);
            REG_BASE:         prdata = APB_DATA_W'(base_reg);
            default:          prdata = '0;
        endcase
    end

    // a zero length is used as one, anything past the supported length saturates
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LEN_W'(1);
        else if (len_reg > LEN_W'(LIMIT_LEN))
            len_eff = LEN_W'(LIMIT_LEN);
        else
            len_eff = len_reg;
    end

    assign cfg.sig  = {pat_high_reg, pat_low_reg};
    assign cfg.wild = wild_reg;
    assign cfg.len  = len_eff;
    assign cfg.base = base_reg;

endmodule

@@ hw/rtl/wbps_cell.sv @@
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              shift,
    input  logic [BYTE_W-1:0] data_in,
    input  cfg_t              cfg,
    output logic [BYTE_W-1:0] data_out,
    output logic              miss
);

    logic [BYTE_W-1:0]    byte_reg;
    logic [LEN_W-1:0]     k_full;
    logic [SIG_IDX_W-1:0] k;
    logic                 in_use;

    always_ff @(posedge clk)
    begin
        if (shift)
            byte_reg <= data_in;
    end

    // this cell holds the byte INDEX+1 places back, so it lines up with
    // signature byte len-2-INDEX
    assign in_use = (LEN_W'(INDEX + 2) <= cfg.len);
    assign k_full = cfg.len - LEN_W'(INDEX + 2);
    assign k      = k_full[SIG_IDX_W-1:0];
    assign miss   = in_use && !cfg.wild[k] && (byte_reg != cfg.sig[k]);

    assign data_out = byte_reg;

endmodule

@@ hw/rtl/wildcard_byte_pattern_scan.sv @@
// A result appears on the output register in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless the result stalls; every alignment check is done in
// parallel by the window cell row, one cell per held byte, so each byte is compared on arrival.
// Reset: rst_n (async, active low) clears the registers to zero, length to one, the byte
// count, the match flag and the output valid. Window bytes need no clear.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN  = DEF_MAX_PATTERN,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    wbps_in_if.sink               bytes,
    wbps_out_if.source            result
);

    localparam int LIMIT_LEN = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;
    localparam int CELLS     = LIMIT_LEN - 1;

    cfg_t                     cfg;
    logic [CELLS-1:0]         cell_miss;
    logic [BYTE_W-1:0]        chain [CELLS+1];

    logic [ADDRESS_BITS-1:0]  offset_reg, offset_next;
    logic                     reported_reg, reported_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [OUT_ADDR_W-1:0]    addr_reg, addr_next;

    logic                     accept;
    logic                     shift;
    logic                     head_miss;
    logic                     hit;
    logic                     emit;
    logic [LEN_W-1:0]         len_m1;
    logic [SIG_IDX_W-1:0]     head_k;
    logic [ADDRESS_BITS-1:0]  start_addr;

    wbps_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign chain[0] = bytes.data_byte;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        wbps_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .data_in  (chain[i]),
            .cfg      (cfg),
            .data_out (chain[i+1]),
            .miss     (cell_miss[i])
        );
    end

    assign bytes.ready = !out_valid_reg || result.ready;
    assign accept      = bytes.valid && bytes.ready;

    // newest byte lines up with the final signature byte
    assign len_m1    = cfg.len - LEN_W'(1);
    assign head_k    = len_m1[SIG_IDX_W-1:0];
    assign head_miss = !cfg.wild[head_k] && (bytes.data_byte != cfg.sig[head_k]);

    assign hit  = !reported_reg && (offset_reg >= ADDRESS_BITS'(len_m1))
                  && !head_miss && !(|cell_miss);
    assign emit = accept && !reported_reg && (hit || bytes.last_byte);
    assign shift = accept && !bytes.last_byte && !reported_reg && !hit;

    assign start_addr = ADDRESS_BITS'(cfg.base) + offset_reg - ADDRESS_BITS'(len_m1);

    always_comb
    begin
        offset_next    = offset_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;

        if (accept)
        begin
            if (bytes.last_byte)
            begin
                offset_next   = '0;
                reported_next = 1'b0;
            end
            else if (hit)
                reported_next = 1'b1;
            else if (!reported_reg)
                offset_next = offset_reg + ADDRESS_BITS'(1);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            found_next     = hit;
            addr_next      = hit ? OUT_ADDR_W'(start_addr) : '0;
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = found_reg;
    assign result.match_address = addr_reg;

    a_notfound_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> addr_reg == '0)
        else $error("not-found beat carries a nonzero address");

    a_rose_reported_emits: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(reported_reg) |-> out_valid_reg && found_reg)
        else $error("match flagged without a found beat");

    a_offset_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg && $past(reported_reg) |-> $stable(offset_reg))
        else $error("byte count moved after a match");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule

@@ sim/wildcard_byte_pattern_scan_tb.sv @@
module wildcard_byte_pattern_scan_tb;
    import wbps_pkg::*;

    localparam int WINDOW_DEPTH = DEF_MAX_PATTERN - 1;
    localparam int LEN_LIMIT    = (DEF_MAX_PATTERN < SIG_BYTES) ? DEF_MAX_PATTERN : SIG_BYTES;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic        found;
        logic [31:0] match_address;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wbps_in_if  bytes_if ();
    wbps_out_if result_if ();

    wildcard_byte_pattern_scan i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bytes   (bytes_if),
        .result  (result_if)
    );

    // shadow copy of the registers
    logic [63:0]       cfg_pat_lo;
    logic [63:0]       cfg_pat_hi;
    logic [15:0]       cfg_wild;
    logic [LEN_W-1:0]  cfg_len;
    logic [31:0]       cfg_base;

    // shadow scan state
    logic [7:0]        recent_bytes [WINDOW_DEPTH];
    logic [31:0]       region_count;
    bit                hit_reported;

    scan_result_t      pending_results [$];
    int                fail_count;
    int                quiet_cycles;
    bit                idling_on;
    int                ready_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_len();
        int n = cfg_len;
        if (n == 0)
            n = 1;
        if (n > LEN_LIMIT)
            n = LEN_LIMIT;
        return n;
    endfunction

    function automatic logic [7:0] sig_byte(int k);
        return (k < 8) ? cfg_pat_lo[8*k +: 8] : cfg_pat_hi[8*(k-8) +: 8];
    endfunction

    task automatic scan_byte(input logic [7:0] cur, input logic last);
        int           len;
        bit           hit;
        logic [7:0]   b;
        scan_result_t res;
        len = eff_len();
        if (!hit_reported)
        begin
            if (region_count >= 32'(len - 1))
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                begin
                    if (!cfg_wild[k])
                    begin
                        b = (k == len - 1) ? cur : recent_bytes[len - 2 - k];
                        if (b != sig_byte(k))
                            hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    res.found         = 1'b1;
                    res.match_address = cfg_base + region_count - 32'(len - 1);
                    pending_results = {pending_results, res};
                    hit_reported = 1'b1;
                end
            end
            if (!hit_reported && last)
            begin
                res.found         = 1'b0;
                res.match_address = '0;
                pending_results = {pending_results, res};
            end
        end
        if (last)
        begin
            foreach (recent_bytes[i])
                recent_bytes[i] = '0;
            region_count = '0;
            hit_reported = 1'b0;
        end
        else if (!hit_reported)
        begin
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                recent_bytes[i] = recent_bytes[i-1];
            recent_bytes[0] = cur;
            region_count++;
        end
    endtask

    // beat monitor: predict on input beats, check on output beats
    always @(posedge clk)
    begin
        scan_result_t exp_res;
        if (rst_n)
        begin
            if (bytes_if.valid && bytes_if.ready)
                scan_byte(bytes_if.data_byte, bytes_if.last_byte);
            if (result_if.valid && result_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual found=%0b addr=%h",
                             $time, result_if.found, result_if.match_address);
                    fail_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (result_if.found !== exp_res.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, exp_res.found, result_if.found);
                        fail_count++;
                    end
                    if (result_if.match_address !== exp_res.match_address)
                    begin
                        $display("%0t: match_address mismatch: expected %h, actual %h",
                                 $time, exp_res.match_address, result_if.match_address);
                        fail_count++;
                    end
                end
            end
            if ((bytes_if.valid && bytes_if.ready) || (result_if.valid && result_if.ready)
                || (psel && penable && pwrite && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure in random bursts
    initial
    begin
        result_if.ready = 1'b0;
        ready_stall     = 0;
        forever
        begin
            @(negedge clk);
            if (ready_stall > 0)
            begin
                ready_stall--;
                result_if.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                ready_stall = $urandom_range(1, 10) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_LSB;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:  cfg_pat_lo = value;
            REG_PATTERN_HIGH: cfg_pat_hi = value;
            REG_WILDCARD:     cfg_wild   = value[15:0];
            REG_LENGTH:       cfg_len    = value[LEN_W-1:0];
            REG_BASE:         cfg_base   = value[31:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            bytes_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bytes_if.valid     <= 1'b1;
        bytes_if.data_byte <= data;
        bytes_if.last_byte <= last;
        @(posedge clk);
        while (!bytes_if.ready)
            @(posedge clk);
    endtask

    // stop sending, let every expected result arrive, then let the pipe drain
    task automatic wait_idle();
        @(negedge clk);
        bytes_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_defaults();
        // reset config: one-byte signature 0x00
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);   // after a hit: silent rearm
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);   // hit on the final byte
    endtask

    task automatic test_short_region();
        wait_idle();
        write_reg(REG_PATTERN_LOW, 64'h4433_2211);
        write_reg(REG_WILDCARD, 64'h0);
        write_reg(REG_LENGTH, 64'd4);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_match_on_last();
        wait_idle();
        write_reg(REG_WILDCARD, 64'h0002);
        write_reg(REG_BASE, 64'hFFFF_FFFE);
        // hit starts at offset 2, address wraps to zero
        send_byte(8'h99, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
    endtask

    task automatic test_zero_length();
        wait_idle();
        write_reg(REG_LENGTH, 64'd0);
        write_reg(REG_WILDCARD, 64'hFFFF);
        send_byte(8'h5C, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    task automatic test_mid_region_config();
        wait_idle();
        write_reg(REG_PATTERN_LOW, 64'hCDAB);
        write_reg(REG_WILDCARD, 64'h0);
        write_reg(REG_LENGTH, 64'd2);
        write_reg(REG_BASE, 64'h100);
        send_byte(8'h11, 1'b0);
        send_byte(8'hAB, 1'b0);
        // region stays open; window must survive the rewrite
        wait_idle();
        write_reg(REG_PATTERN_LOW, 64'h5A_AB11);
        write_reg(REG_LENGTH, 64'd3);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic random_setup();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] wild;
        logic [31:0] base;
        int          len;
        int          pick;
        pick = $urandom_range(0, 9);
        lo   = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        hi   = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        pick = $urandom_range(0, 7);
        wild = (pick == 0) ? 16'h0 : (pick == 1) ? 16'hFFFF
               : 16'($urandom & $urandom & $urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = $urandom_range(17, 31);
        else if (pick < 4)
            len = $urandom_range(5, 16);
        else
            len = $urandom_range(1, 4);
        pick = $urandom_range(0, 7);
        base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_WILDCARD, 64'(wild));
        write_reg(REG_LENGTH, 64'(len));
        write_reg(REG_BASE, 64'(base));
    endtask

    task automatic test_random_regions();
        int         sent;
        int         regions_left;
        int         len;
        int         region_len;
        int         pos;
        bit         plant;
        logic [7:0] b;
        sent         = 0;
        regions_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (regions_left == 0)
            begin
                wait_idle();
                random_setup();
                regions_left = $urandom_range(1, 5);
            end
            len = eff_len();
            plant = ($urandom_range(0, 9) < 7);
            if (plant)
            begin
                region_len = len + $urandom_range(0, 24);
                pos        = $urandom_range(0, region_len - len);
            end
            else
            begin
                region_len = $urandom_range(1, 24);
                pos        = 0;
            end
            for (int i = 0; i < region_len; i++)
            begin
                // near-miss bytes drawn from the signature keep partial matches frequent
                if (plant && i >= pos && i < pos + len && !cfg_wild[i - pos])
                    b = sig_byte(i - pos);
                else if ($urandom_range(0, 1) == 0)
                    b = sig_byte($urandom_range(0, len - 1));
                else
                    b = 8'($urandom_range(0, 255));
                send_byte(b, i == region_len - 1);
                sent++;
            end
            regions_left--;
            if (sent >= RANDOM_ITEMS * 4 / 5)
                idling_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        bytes_if.valid     = 1'b0;
        bytes_if.data_byte = '0;
        bytes_if.last_byte = 1'b0;
        fail_count         = 0;
        idling_on          = 1'b1;
        cfg_pat_lo         = '0;
        cfg_pat_hi         = '0;
        cfg_wild           = '0;
        cfg_len            = LEN_RESET;
        cfg_base           = '0;
        foreach (recent_bytes[i])
            recent_bytes[i] = '0;
        region_count       = '0;
        hit_reported       = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_short_region();
        test_match_on_last();
        test_zero_length();
        test_mid_region_config();
        test_random_regions();

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_if.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_scan.sv
sim/wildcard_byte_pattern_scan_tb.sv
